@@ rtl/sgd_pkg.sv @@
// Shared widths, configuration codes and types for the signed gadget decomposition.
package sgd_pkg;

  localparam int COEF_W        = 64;
  localparam int STATE_W       = 63;
  localparam int DIGIT_W       = 33;
  localparam int LEVEL_W       = 4;
  localparam int BASE_LOG_W    = 6;
  localparam int LEVEL_COUNT_W = 5;
  localparam int CFG_DATA_W    = 6;
  localparam int CFG_INDEX_W   = 1;
  localparam int MAX_BASE_LOG  = 32;
  localparam int MAX_LEVELS    = 16;
  localparam int MAX_TOTAL     = 63;

  localparam logic [BASE_LOG_W-1:0]    BASE_LOG_RESET    = 6'd8;
  localparam logic [LEVEL_COUNT_W-1:0] LEVEL_COUNT_RESET = 5'd2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_BASE_LOG    = 1'b0,
    CFG_LEVEL_COUNT = 1'b1
  } cfg_index_t;

  // Settings decoded from the two registers; the user must hold them steady while items are in flight (unenforced).
  typedef struct packed {
    logic [BASE_LOG_W-1:0]    base_log;
    logic [BASE_LOG_W-1:0]    total;
    logic [BASE_LOG_W-1:0]    shift;
    logic [LEVEL_COUNT_W-1:0] count;
    logic                     err;
  } cfg_t;

endpackage

@@ rtl/sgd_coef_if.sv @@
// Coefficient channel: valid/ready handshake carrying one torus coefficient.
interface sgd_coef_if;
  logic                        valid;
  logic                        ready;
  logic [sgd_pkg::COEF_W-1:0]  coefficient;

  modport source (output valid, output coefficient, input ready);
  modport sink   (input valid, input coefficient, output ready);
endinterface

@@ rtl/sgd_digit_if.sv @@
// Digit channel: valid/ready handshake carrying one signed digit and its tags.
interface sgd_digit_if;
  logic                               valid;
  logic                               ready;
  logic signed [sgd_pkg::DIGIT_W-1:0] digit;
  logic [sgd_pkg::LEVEL_W-1:0]        level;
  logic                               last;
  logic                               error;

  modport source (output valid, output digit, output level, output last, output error,
                  input ready);
  modport sink   (input valid, input digit, input level, input last, input error,
                  output ready);
endinterface

@@ rtl/signed_gadget_decomposition.sv @@
// Top level of the signed gadget decomposition: configuration registers and pipeline.
//
// Each 64-bit coefficient beat is rounded to its top level_count*base_log bits and
// split into level_count balanced signed digits, least significant level first
// (level level_count-1 down to 0, last set on level 0). The pipeline has three
// register stages ahead of the sequencer (align, round, load) and a registered
// output. The digit sequencer produces one digit per cycle while the output is not
// stalled, and the next coefficient loads in the same cycle as the previous one's
// final digit. Bad settings (base_log of 0 or above 32, level_count of 0 or above 16,
// product above 63) raise error on every beat with zero digits; level_count of 0 gives
// one beat, above 16 gives sixteen.
// Write the configuration only while no coefficient is in flight.
module signed_gadget_decomposition (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [sgd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [sgd_pkg::CFG_DATA_W-1:0]    cfg_data,
  sgd_coef_if.sink                          coefs,
  sgd_digit_if.source                       digits
);

  logic [sgd_pkg::BASE_LOG_W-1:0]    base_log;
  logic [sgd_pkg::LEVEL_COUNT_W-1:0] level_count;
  logic [10:0]                       product;
  sgd_pkg::cfg_t                     cfg;

  logic                              st_valid;
  logic [sgd_pkg::STATE_W-1:0]       st;
  logic                              st_ready;

  // Register writes: index selects the register, data is truncated to its width.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_log    <= sgd_pkg::BASE_LOG_RESET;
      level_count <= sgd_pkg::LEVEL_COUNT_RESET;
    end else if (cfg_we) begin
      case (sgd_pkg::cfg_index_t'(cfg_index))
        sgd_pkg::CFG_BASE_LOG:    base_log    <= cfg_data;
        sgd_pkg::CFG_LEVEL_COUNT: level_count <= cfg_data[sgd_pkg::LEVEL_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Decode the settings; the user must keep them fixed while beats are in flight, which is not enforced here.
  always_comb begin
    product      = 11'(base_log) * 11'(level_count);
    cfg.base_log = base_log;
    cfg.err      = (base_log == '0) || (base_log > 6'(sgd_pkg::MAX_BASE_LOG))
                   || (level_count == '0) || (level_count > 5'(sgd_pkg::MAX_LEVELS))
                   || (product > 11'(sgd_pkg::MAX_TOTAL));
    cfg.total    = product[sgd_pkg::BASE_LOG_W-1:0];
    cfg.shift    = 6'(sgd_pkg::MAX_TOTAL) - product[sgd_pkg::BASE_LOG_W-1:0];
    if (level_count == '0) begin
      cfg.count = 5'd1;
    end else if (level_count > 5'(sgd_pkg::MAX_LEVELS)) begin
      cfg.count = 5'(sgd_pkg::MAX_LEVELS);
    end else begin
      cfg.count = level_count;
    end
  end

  sgd_round u_round (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .coefs    (coefs),
    .st_valid (st_valid),
    .st       (st),
    .st_ready (st_ready)
  );

  sgd_digit u_digit (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .st_valid (st_valid),
    .st       (st),
    .st_ready (st_ready),
    .digits   (digits)
  );

endmodule

@@ rtl/sgd_round.sv @@
// Two-stage front end: align the coefficient, then round it into the digit state.
module sgd_round (
  input  logic                          clk,
  input  logic                          rst,
  input  sgd_pkg::cfg_t                 cfg,
  sgd_coef_if.sink                      coefs,
  output logic                          st_valid,
  output logic [sgd_pkg::STATE_W-1:0]   st,
  input  logic                          st_ready
);

  logic                          s1_valid;
  logic [sgd_pkg::COEF_W-1:0]    s1_shifted;
  logic                          s2_valid;
  logic [sgd_pkg::STATE_W-1:0]   s2_state;

  logic                          s1_adv;
  logic                          s2_adv;
  logic [sgd_pkg::COEF_W:0]      rounded;
  logic [sgd_pkg::COEF_W-1:0]    total_mask;
  logic [sgd_pkg::STATE_W-1:0]   s2_state_next;

  assign s2_adv      = !s2_valid || st_ready;
  assign s1_adv      = !s1_valid || s2_adv;
  assign coefs.ready = s1_adv;

  // Add half an LSB at the round position, drop the round bit, keep total bits.
  always_comb begin
    rounded       = ({1'b0, s1_shifted} + {{sgd_pkg::COEF_W{1'b0}}, 1'b1}) >> 1;
    total_mask    = ({{(sgd_pkg::COEF_W-1){1'b0}}, 1'b1} << cfg.total)
                    - {{(sgd_pkg::COEF_W-1){1'b0}}, 1'b1};
    s2_state_next = rounded[sgd_pkg::STATE_W-1:0] & total_mask[sgd_pkg::STATE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid <= coefs.valid;
      end
      if (s2_adv) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_shifted <= coefs.coefficient >> cfg.shift;
    end
    if (s2_adv) begin
      s2_state <= s2_state_next;
    end
  end

  assign st_valid = s2_valid;
  assign st       = s2_state;

endmodule

@@ rtl/sgd_digit.sv @@
// Digit sequencer: peel one balanced digit per cycle, when the output is not stalled, into a registered output.
module sgd_digit (
  input  logic                          clk,
  input  logic                          rst,
  input  sgd_pkg::cfg_t                 cfg,
  input  logic                          st_valid,
  input  logic [sgd_pkg::STATE_W-1:0]   st,
  output logic                          st_ready,
  sgd_digit_if.source                   digits
);

  logic                               busy;
  logic [sgd_pkg::LEVEL_W-1:0]        lvl;
  logic [sgd_pkg::STATE_W-1:0]        state;
  logic                               out_valid;
  logic signed [sgd_pkg::DIGIT_W-1:0] out_digit;
  logic [sgd_pkg::LEVEL_W-1:0]        out_level;
  logic                               out_last;
  logic                               out_error;

  logic                               adv;
  logic                               step;
  logic                               load;
  logic [sgd_pkg::DIGIT_W-1:0]        mask;
  logic [4:0]                         bm1;
  logic [31:0]                        d;
  logic [31:0]                        half;
  logic [sgd_pkg::STATE_W-1:0]        rest;
  logic                               carry;
  logic [sgd_pkg::DIGIT_W-1:0]        digit_val;
  logic [sgd_pkg::STATE_W-1:0]        state_next;

  assign adv      = !out_valid || digits.ready;
  assign step     = busy && adv;
  assign st_ready = !busy || (adv && (lvl == '0));
  assign load     = st_valid && st_ready;

  always_comb begin
    mask  = ({{(sgd_pkg::DIGIT_W-1){1'b0}}, 1'b1} << cfg.base_log)
            - {{(sgd_pkg::DIGIT_W-1){1'b0}}, 1'b1};
    bm1   = 5'(cfg.base_log - 6'd1);
    d     = state[31:0] & mask[31:0];
    half  = 32'd1 << bm1;
    rest  = state >> cfg.base_log;
    // Carry when the digit reaches half the base; at exactly half, the top bit of the next digit decides.
    carry = d[bm1] & ((d != half) | rest[bm1]);
    digit_val  = {1'b0, d} - (carry ? ({{(sgd_pkg::DIGIT_W-1){1'b0}}, 1'b1} << cfg.base_log)
                                    : {sgd_pkg::DIGIT_W{1'b0}});
    state_next = rest + {{(sgd_pkg::STATE_W-1){1'b0}}, carry};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        out_valid <= busy;
      end
      if (load) begin
        busy <= 1'b1;
      end else if (step && (lvl == '0)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_digit <= cfg.err ? '0 : signed'(digit_val);
      out_level <= lvl;
      out_last  <= (lvl == '0);
      out_error <= cfg.err;
    end
    if (load) begin
      state <= st;
      lvl   <= 4'(cfg.count - 5'd1);
    end else if (step) begin
      state <= state_next;
      lvl   <= lvl - 4'd1;
    end
  end

  assign digits.valid = out_valid;
  assign digits.digit = out_digit;
  assign digits.level = out_level;
  assign digits.last  = out_last;
  assign digits.error = out_error;

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_error |-> out_digit == '0)
    else $error("error beat carries a non-zero digit");

  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> busy)
    else $error("non-final digit shown while sequencer is idle");

  a_step_out: assert property (@(posedge clk) disable iff (rst)
    busy && adv |=> out_valid)
    else $error("digit step did not fill the output register");

endmodule
